/* hdl/alr_pkg.sv */
// Shared constants and types for the area link reachability unit.
`default_nettype none

package alr_pkg;

   // Area numbering and matrix geometry.
   localparam int NUM_AREAS = 64;
   localparam int AREA_W    = 6;
   localparam int STRIDE    = 64;
   localparam int LINK_W    = 8;
   localparam int ROW_W     = STRIDE * LINK_W;
   localparam int MASK_W    = 64;
   localparam int COUNT_W   = 7;
   localparam int CMD_W     = 2;

   // Bits of the mask that stand for areas that exist.
   localparam logic [MASK_W-1:0] AREA_MASK =
      (NUM_AREAS >= MASK_W) ? {MASK_W{1'b1}} :
      ((MASK_W'(1) << NUM_AREAS) - MASK_W'(1));

   typedef logic [CMD_W-1:0]   cmd_type;
   typedef logic [AREA_W-1:0]  area_type;
   typedef logic [MASK_W-1:0]  mask_type;
   typedef logic [COUNT_W-1:0] count_type;
   typedef logic [ROW_W-1:0]   row_type;
   typedef logic [LINK_W-1:0]  link_type;

   // Command codes.
   localparam cmd_type CMD_INIT       = 2'd0;
   localparam cmd_type CMD_JOIN       = 2'd1;
   localparam cmd_type CMD_DISCONNECT = 2'd2;
   localparam cmd_type CMD_RECOMPUTE  = 2'd3;

endpackage

`default_nettype wire

/* hdl/alr_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
`default_nettype none

module alr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire

/* hdl/alr_ones_counter.sv */
// Population counter that sums one byte of the mask per cycle.
`default_nettype none

module alr_ones_counter (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   input  wire alr_pkg::mask_type word,
   output logic                   done,
   output alr_pkg::count_type     count
);
   import alr_pkg::*;

   localparam int STEPS  = MASK_W / 8;
   localparam int STEP_W = $clog2(STEPS);

   logic                active_ff, active_in;
   logic                done_ff, done_in;
   logic [STEP_W-1:0]   step_ff, step_in;
   mask_type            shift_ff, shift_in;
   count_type           acc_ff, acc_in;

   // Ones in one byte.
   function automatic logic [3:0] pop8(input logic [7:0] v);
      logic [3:0] n;
      n = 4'd0;
      for (int i = 0; i < 8; i++) begin
         n = n + {3'd0, v[i]};
      end
      return n;
   endfunction

   // One byte is added each cycle until the word is used up.
   always_comb begin
      active_in = active_ff;
      done_in   = 1'b0;
      step_in   = step_ff;
      shift_in  = shift_ff;
      acc_in    = acc_ff;
      if (start) begin
         active_in = 1'b1;
         step_in   = '0;
         shift_in  = word;
         acc_in    = '0;
      end else if (active_ff) begin
         acc_in   = acc_ff + COUNT_W'(pop8(shift_ff[7:0]));
         shift_in = shift_ff >> 8;
         step_in  = step_ff + STEP_W'(1);
         if (step_ff == STEP_W'(STEPS - 1)) begin
            active_in = 1'b0;
            done_in   = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         done_ff   <= 1'b0;
         step_ff   <= '0;
      end else begin
         active_ff <= active_in;
         done_ff   <= done_in;
         step_ff   <= step_in;
      end
      shift_ff <= shift_in;
      acc_ff   <= acc_in;
   end

   assign done  = done_ff;
   assign count = acc_ff;

endmodule

`default_nettype wire

/* hdl/area_link_reachability_unit.sv */
// Top level: command sequencer, link matrix in row memory, and flood walk.
`default_nettype none

// Channel    Ports                                   Handshake
// command    req_command, req_area_a, req_area_b     start, busy (accept: start & !busy)
// result     rsp_reachable_mask/_count, rsp_saturated  rsp_strobe, one cycle, no stall
//
// The walk reads one matrix row per cycle from the single read port; the
// count sums the mask one byte at a time.
// Reset clears per-row valid bits at once, so there is no clearing pass.
// The receiver cannot stall; each result word is shown for one cycle.
module area_link_reachability_unit (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   output logic                    busy,
   input  wire alr_pkg::cmd_type   req_command,
   input  wire alr_pkg::area_type  req_area_a,
   input  wire alr_pkg::area_type  req_area_b,
   output logic                    rsp_strobe,
   output alr_pkg::mask_type       rsp_reachable_mask,
   output alr_pkg::count_type      rsp_reachable_count,
   output logic                    rsp_saturated
);
   import alr_pkg::*;

   localparam int ST_W = 3;
   localparam logic [ST_W-1:0] S_IDLE  = 3'd0;
   localparam logic [ST_W-1:0] S_RDA   = 3'd1;
   localparam logic [ST_W-1:0] S_MODA  = 3'd2;
   localparam logic [ST_W-1:0] S_RDB   = 3'd3;
   localparam logic [ST_W-1:0] S_MODB  = 3'd4;
   localparam logic [ST_W-1:0] S_FLOOD = 3'd5;
   localparam logic [ST_W-1:0] S_CNT   = 3'd6;
   localparam logic [ST_W-1:0] S_CWAIT = 3'd7;

   logic [ST_W-1:0]    state_ff, state_in;
   cmd_type            cmd_ff, cmd_in;
   area_type           a_ff, a_in;
   area_type           b_ff, b_in;
   mask_type           reached_ff, reached_in;
   mask_type           done_ff, done_in;
   mask_type           row_valid_ff, row_valid_in;
   logic               inflight_ff, inflight_in;
   area_type           flood_row_ff, flood_row_in;
   logic               sat_ff, sat_in;
   count_type          count_ff, count_in;
   logic               strobe_ff, strobe_in;

   logic               wr_en;
   area_type           wr_addr;
   row_type            wr_row;
   area_type           rd_addr;
   row_type            rd_data;

   logic               cnt_start;
   logic               cnt_done;
   count_type          cnt_value;

   logic               a_ok, b_ok, req_a_ok;
   row_type            cur_row;
   area_type           byte_sel;
   link_type           cur_link, new_link;
   logic               link_sat;
   mask_type           nbr;
   mask_type           merged;
   mask_type           pend;
   area_type           pick;

   // Link matrix, one row of counts per area.
   alr_ram #(
      .WIDTH(ROW_W),
      .DEPTH(STRIDE)
   ) u_matrix (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_row),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Shared ones counter for the reachable count.
   alr_ones_counter u_counter (
      .clock (clock),
      .reset (reset),
      .start (cnt_start),
      .word  (reached_ff),
      .done  (cnt_done),
      .count (cnt_value)
   );

   assign a_ok     = {1'b0, a_ff} < (AREA_W + 1)'(NUM_AREAS);
   assign b_ok     = {1'b0, b_ff} < (AREA_W + 1)'(NUM_AREAS);
   assign req_a_ok = {1'b0, req_area_a} < (AREA_W + 1)'(NUM_AREAS);

   // Row being modified reads as zero until it has been written since init.
   always_comb begin
      byte_sel = (state_ff == S_MODB) ? a_ff : b_ff;
      cur_row  = row_valid_ff[wr_addr] ? rd_data : '0;
      cur_link = cur_row[byte_sel*LINK_W +: LINK_W];
      if (cmd_ff == CMD_JOIN) begin
         link_sat = (cur_link == {LINK_W{1'b1}});
         new_link = link_sat ? cur_link : cur_link + LINK_W'(1);
      end else begin
         link_sat = (cur_link == '0);
         new_link = link_sat ? cur_link : cur_link - LINK_W'(1);
      end
      wr_row = cur_row;
      wr_row[byte_sel*LINK_W +: LINK_W] = new_link;
   end

   // Neighbors from the row that returned for the walk.
   always_comb begin
      for (int i = 0; i < MASK_W; i++) begin
         nbr[i] = (rd_data[i*LINK_W +: LINK_W] != '0);
      end
      nbr = row_valid_ff[flood_row_ff] ? (nbr & AREA_MASK) : '0;
      merged = reached_ff | (inflight_ff ? nbr : '0);
      pend   = merged & ~done_ff;
   end

   // Lowest pending area is visited next.
   always_comb begin
      pick = '0;
      for (int i = MASK_W - 1; i >= 0; i--) begin
         if (pend[i]) begin
            pick = AREA_W'(i);
         end
      end
   end

   // Command sequencer.
   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      reached_in   = reached_ff;
      done_in      = done_ff;
      row_valid_in = row_valid_ff;
      inflight_in  = inflight_ff;
      flood_row_in = flood_row_ff;
      sat_in       = sat_ff;
      count_in     = count_ff;
      strobe_in    = 1'b0;
      wr_en        = 1'b0;
      wr_addr      = (state_ff == S_MODB) ? b_ff : a_ff;
      rd_addr      = a_ff;
      cnt_start    = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd_in = req_command;
               a_in   = req_area_a;
               b_in   = req_area_b;
               sat_in = 1'b0;
               unique case (req_command)
                  CMD_INIT: begin
                     row_valid_in = '0;
                     reached_in   = req_a_ok ? (MASK_W'(1) << req_area_a) : '0;
                     state_in     = S_CNT;
                  end
                  CMD_JOIN, CMD_DISCONNECT: begin
                     state_in = S_RDA;
                  end
                  default: begin
                     reached_in   = req_a_ok ? (MASK_W'(1) << req_area_a) : '0;
                     done_in      = '0;
                     inflight_in  = 1'b0;
                     state_in     = req_a_ok ? S_FLOOD : S_CNT;
                  end
               endcase
            end
         end
         S_RDA: begin
            rd_addr  = a_ff;
            state_in = (a_ok && b_ok) ? S_MODA : S_CNT;
         end
         S_MODA: begin
            wr_en                 = 1'b1;
            row_valid_in[a_ff]    = 1'b1;
            sat_in                = link_sat;
            state_in              = S_RDB;
         end
         S_RDB: begin
            rd_addr  = b_ff;
            state_in = S_MODB;
         end
         S_MODB: begin
            wr_en                 = 1'b1;
            row_valid_in[b_ff]    = 1'b1;
            sat_in                = sat_ff | link_sat;
            state_in              = S_CNT;
         end
         S_FLOOD: begin
            reached_in = merged;
            rd_addr    = pick;
            if (pend != '0) begin
               done_in      = done_ff | (MASK_W'(1) << pick);
               inflight_in  = 1'b1;
               flood_row_in = pick;
            end else begin
               inflight_in = 1'b0;
               if (!inflight_ff) begin
                  state_in = S_CNT;
               end
            end
         end
         S_CNT: begin
            cnt_start = 1'b1;
            state_in  = S_CWAIT;
         end
         S_CWAIT: begin
            if (cnt_done) begin
               count_in  = cnt_value;
               strobe_in = 1'b1;
               state_in  = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control state and the reached set are reset; other payload registers are not.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         reached_ff   <= '0;
         row_valid_ff <= '0;
         inflight_ff  <= 1'b0;
         strobe_ff    <= 1'b0;
      end else begin
         state_ff     <= state_in;
         reached_ff   <= reached_in;
         row_valid_ff <= row_valid_in;
         inflight_ff  <= inflight_in;
         strobe_ff    <= strobe_in;
      end
      cmd_ff       <= cmd_in;
      a_ff         <= a_in;
      b_ff         <= b_in;
      done_ff      <= done_in;
      flood_row_ff <= flood_row_in;
      sat_ff       <= sat_in;
      count_ff     <= count_in;
   end

   assign busy                = (state_ff != S_IDLE);
   assign rsp_strobe          = strobe_ff;
   assign rsp_reachable_mask  = reached_ff;
   assign rsp_reachable_count = count_ff;
   assign rsp_saturated       = sat_ff;

endmodule

`default_nettype wire

/* test/tb_top.sv */
// Testbench for the area link reachability unit: random command words checked against a predictor.
`timescale 1ns / 100ps

module tb_top;
   import alr_pkg::*;

   localparam int RUN_LIMIT    = 1_000_000;
   localparam int TARGET_WORDS = 1550;
   localparam int DRAIN_CYCLES = NUM_AREAS + 16;

   // Expected contents of one result word.
   typedef struct {
      mask_type  mask;
      count_type count;
      logic      saturated;
   } reach_report_type;

   // Keeps a private copy of the link matrix and the reached set, and checks results.
   class reach_scoreboard;
      link_type         pair_links [NUM_AREAS][NUM_AREAS];
      mask_type         reached;
      reach_report_type awaited_reports [$];
      int               errors;
      int               checked;
      int               sat_flags;
      int               full_walks;
      int               per_command [4];

      function new();
         foreach (pair_links[i, j]) pair_links[i][j] = '0;
         reached = '0;
         errors = 0;
         checked = 0;
         sat_flags = 0;
         full_walks = 0;
         foreach (per_command[i]) per_command[i] = 0;
      endfunction

      // A link already at its top value stays there and reports saturation.
      function bit raise_link(int a, int b);
         if (pair_links[a][b] == '1) return 1'b1;
         pair_links[a][b]++;
         return 1'b0;
      endfunction

      // A link already at zero stays there and reports saturation.
      function bit lower_link(int a, int b);
         if (pair_links[a][b] == '0) return 1'b1;
         pair_links[a][b]--;
         return 1'b0;
      endfunction

      // Visits every area reachable from the origin over nonzero links.
      function mask_type flood_from(area_type origin);
         mask_type seen;
         mask_type visited;
         mask_type frontier;
         int       a;
         seen = mask_type'(1) << origin;
         visited = '0;
         frontier = seen;
         while (frontier != '0) begin
            for (a = 0; a < NUM_AREAS; a++) if (frontier[a]) break;
            visited[a] = 1'b1;
            for (int i = 0; i < NUM_AREAS; i++) if (pair_links[a][i] != '0) seen[i] = 1'b1;
            frontier = seen & ~visited;
         end
         return seen;
      endfunction

      // Applies an accepted command word and queues the result it must produce.
      function void note_command(cmd_type cmd, area_type a, area_type b);
         reach_report_type report;
         bit               hit_a;
         bit               hit_b;
         report.saturated = 1'b0;
         per_command[cmd]++;
         case (cmd)
            CMD_INIT: begin
               foreach (pair_links[i, j]) pair_links[i][j] = '0;
               reached = mask_type'(1) << a;
            end
            CMD_JOIN: begin
               hit_a = raise_link(a, b);
               hit_b = raise_link(b, a);
               report.saturated = hit_a | hit_b;
            end
            CMD_DISCONNECT: begin
               hit_a = lower_link(a, b);
               hit_b = lower_link(b, a);
               report.saturated = hit_a | hit_b;
            end
            default: begin
               reached = flood_from(a);
               if (reached == '1) full_walks++;
            end
         endcase
         report.mask = reached;
         report.count = count_type'($countones(reached));
         awaited_reports.push_back(report);
      endfunction

      // Compares one result word with the oldest expectation.
      function void check_result(mask_type mask, count_type count, logic saturated);
         reach_report_type want;
         if (awaited_reports.size() == 0) begin
            $error("result word with no command waiting: mask %h count %0d", mask, count);
            errors++;
            return;
         end
         want = awaited_reports.pop_front();
         checked++;
         if (saturated === 1'b1) sat_flags++;
         if (mask !== want.mask) begin
            $error("reachable_mask: expected %h, got %h", want.mask, mask);
            errors++;
         end
         if (count !== want.count) begin
            $error("reachable_count: expected %0d, got %0d", want.count, count);
            errors++;
         end
         if (saturated !== want.saturated) begin
            $error("saturated: expected %0b, got %0b", want.saturated, saturated);
            errors++;
         end
      endfunction
   endclass

   logic      clock = 1'b0;
   logic      reset = 1'b1;
   logic      start = 1'b0;
   logic      busy;
   cmd_type   req_command = CMD_INIT;
   area_type  req_area_a = '0;
   area_type  req_area_b = '0;
   logic      rsp_strobe;
   mask_type  rsp_reachable_mask;
   count_type rsp_reachable_count;
   logic      rsp_saturated;

   reach_scoreboard sb;
   int cycle_count = 0;
   int words_sent = 0;
   int burst_left = 0;

   area_link_reachability_unit DUT (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .busy                (busy),
      .req_command         (req_command),
      .req_area_a          (req_area_a),
      .req_area_b          (req_area_b),
      .rsp_strobe          (rsp_strobe),
      .rsp_reachable_mask  (rsp_reachable_mask),
      .rsp_reachable_count (rsp_reachable_count),
      .rsp_saturated       (rsp_saturated)
   );

   always #10 clock = ~clock;

   // The run is cut off if it takes far longer than the slowest correct run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= RUN_LIMIT) begin
         $display("[area_link_reachability_unit] ERROR");
         $finish;
      end
   end

   // Every strobed result word is checked at the edge that ends its cycle.
   always @(posedge clock) begin
      if (!reset && rsp_strobe === 1'b1) begin
         sb.check_result(rsp_reachable_mask, rsp_reachable_count, rsp_saturated);
      end
   end

   // Holds start low for some cycles with noise on the command fields.
   task automatic idle_cycles(int n);
      repeat (n) begin
         @(negedge clock);
         start <= 1'b0;
         req_command <= cmd_type'($urandom_range(0, 3));
         req_area_a <= area_type'($urandom_range(0, 63));
         req_area_b <= area_type'($urandom_range(0, 63));
      end
   endtask

   // Presents one command word and waits until the block takes it.
   task automatic send_word(cmd_type cmd, area_type a, area_type b);
      int pick;
      if (burst_left == 0) begin
         pick = $urandom_range(0, 99);
         if (pick < 70) idle_cycles($urandom_range(1, 6));
         else if (pick < 95) idle_cycles($urandom_range(7, 40));
         else idle_cycles($urandom_range(60, 90));
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
                                                  : $urandom_range(1, 12);
      end
      burst_left--;
      @(negedge clock);
      start <= 1'b1;
      req_command <= cmd;
      req_area_a <= a;
      req_area_b <= b;
      @(posedge clock);
      while (busy !== 1'b0) @(posedge clock);
      sb.note_command(cmd, a, b);
      words_sent++;
   endtask

   function automatic area_type any_area();
      return area_type'($urandom_range(0, 63));
   endfunction

   // Field extremes, every command, self links and saturation at zero.
   task automatic run_directed();
      send_word(CMD_INIT, 6'd0, 6'd0);
      send_word(CMD_RECOMPUTE, 6'd0, 6'd63);
      send_word(CMD_INIT, 6'd63, 6'd63);
      send_word(CMD_RECOMPUTE, 6'd63, 6'd0);
      send_word(CMD_JOIN, 6'd0, 6'd63);
      send_word(CMD_JOIN, 6'd63, 6'd63);
      send_word(CMD_RECOMPUTE, 6'd0, 6'd0);
      send_word(CMD_JOIN, 6'd21, 6'd42);
      send_word(CMD_RECOMPUTE, 6'd21, 6'd21);
      send_word(CMD_JOIN, 6'd42, 6'd0);
      send_word(CMD_RECOMPUTE, 6'd63, 6'd42);
      send_word(CMD_DISCONNECT, 6'd0, 6'd63);
      send_word(CMD_RECOMPUTE, 6'd63, 6'd63);
      send_word(CMD_DISCONNECT, 6'd63, 6'd0);
      send_word(CMD_DISCONNECT, 6'd7, 6'd7);
      send_word(CMD_JOIN, 6'd42, 6'd42);
      send_word(CMD_DISCONNECT, 6'd42, 6'd42);
      send_word(CMD_DISCONNECT, 6'd42, 6'd42);
      send_word(CMD_RECOMPUTE, 6'd42, 6'd42);
      send_word(CMD_INIT, 6'd42, 6'd21);
      send_word(CMD_RECOMPUTE, 6'd21, 6'd42);
   endtask

   // Drives one pair past its top count and then back below zero.
   task automatic hammer_pair(bit self_link);
      area_type a;
      area_type b;
      int       ups;
      a = any_area();
      b = self_link ? a : area_type'(a ^ area_type'($urandom_range(1, 63)));
      ups = self_link ? 130 : 257;
      send_word(CMD_INIT, a, any_area());
      repeat (ups) send_word(CMD_JOIN, a, b);
      send_word(CMD_RECOMPUTE, b, any_area());
      repeat (self_link ? 130 : 258) send_word(CMD_DISCONNECT, b, a);
      send_word(CMD_RECOMPUTE, a, any_area());
   endtask

   // Builds a random graph among a few areas with walks along the way.
   task automatic grow_cluster();
      area_type group [$];
      int       ops;
      int       pick;
      repeat ($urandom_range(2, 10)) group.push_back(any_area());
      send_word(CMD_INIT, group[0], any_area());
      ops = $urandom_range(5, 25);
      repeat (ops) begin
         pick = $urandom_range(0, 9);
         if (pick < 6) begin
            send_word(CMD_JOIN, group[$urandom_range(0, group.size() - 1)],
                      group[$urandom_range(0, group.size() - 1)]);
         end else if (pick < 8) begin
            send_word(CMD_DISCONNECT, group[$urandom_range(0, group.size() - 1)],
                      group[$urandom_range(0, group.size() - 1)]);
         end else begin
            send_word(CMD_RECOMPUTE, group[$urandom_range(0, group.size() - 1)], any_area());
         end
      end
      send_word(CMD_RECOMPUTE, group[$urandom_range(0, group.size() - 1)], any_area());
   endtask

   // Links all areas in one shuffled chain, walks it, then cuts it and walks again.
   task automatic chain_all_areas();
      int order [NUM_AREAS];
      int j;
      int swap;
      int cut;
      foreach (order[i]) order[i] = i;
      for (int i = NUM_AREAS - 1; i > 0; i--) begin
         j = $urandom_range(0, i);
         swap = order[i];
         order[i] = order[j];
         order[j] = swap;
      end
      send_word(CMD_INIT, any_area(), any_area());
      for (int i = 0; i < NUM_AREAS - 1; i++) begin
         send_word(CMD_JOIN, area_type'(order[i]), area_type'(order[i + 1]));
      end
      send_word(CMD_RECOMPUTE, any_area(), any_area());
      cut = $urandom_range(0, NUM_AREAS - 2);
      send_word(CMD_DISCONNECT, area_type'(order[cut + 1]), area_type'(order[cut]));
      send_word(CMD_RECOMPUTE, area_type'(order[$urandom_range(0, NUM_AREAS - 1)]), any_area());
   endtask

   // Mostly well-formed sequences, with a share of unrelated random words.
   task automatic run_random();
      int pick;
      hammer_pair(1'b1);
      hammer_pair(1'b0);
      while (words_sent < TARGET_WORDS) begin
         pick = $urandom_range(0, 99);
         if (pick < 70) begin
            grow_cluster();
         end else if (pick < 80) begin
            chain_all_areas();
         end else begin
            repeat ($urandom_range(10, 30)) begin
               send_word(cmd_type'($urandom_range(0, 3)), any_area(), any_area());
            end
         end
      end
   endtask

   initial begin
      sb = new();
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      run_directed();
      run_random();
      @(negedge clock);
      start <= 1'b0;
      while (sb.awaited_reports.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Sent %0d words: %0d init, %0d join, %0d disconnect, %0d recompute.",
               words_sent, sb.per_command[CMD_INIT], sb.per_command[CMD_JOIN],
               sb.per_command[CMD_DISCONNECT], sb.per_command[CMD_RECOMPUTE]);
      $display("Checked %0d results; %0d flagged saturation, %0d walks reached all areas.",
               sb.checked, sb.sat_flags, sb.full_walks);
      if (sb.errors == 0 && sb.awaited_reports.size() == 0) begin
         $display("[area_link_reachability_unit] OK");
      end else begin
         $display("[area_link_reachability_unit] ERROR");
      end
      $finish;
   end

endmodule
